// ===== hdl/ogme_pkg.sv =====
// Shared types, codes and constant tables for the online geometric median estimator.
// No dependencies; used by the top level.
package ogme_pkg;

    // Built maximum of coordinates per vector
    localparam int unsigned MAX_DIM_DEF = 16;

    // Register reset values
    localparam logic [6:0]  DIM_RST   = 7'd16;
    localparam logic [15:0] GAMMA_RST = 16'd512;
    localparam logic [15:0] ALPHA_RST = 16'd49152;
    localparam logic [31:0] EPS_RST   = 32'd1;

    // Action codes carried in tuser
    typedef enum logic [1:0] {
        ACT_LOAD   = 2'd0,
        ACT_BEGIN  = 2'd1,
        ACT_SAMPLE = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    // Register indexes (word address)
    typedef enum logic [1:0] {
        REG_DIM   = 2'd0,
        REG_GAMMA = 2'd1,
        REG_ALPHA = 2'd2,
        REG_EPS   = 2'd3
    } t_reg_idx;

    // Sequencer states
    typedef enum logic [4:0] {
        S_IDLE, S_D_RD, S_D_SQ, S_D_ACC, S_DIST_GO, S_DIST_WT,
        S_NORM, S_LOG_MUL, S_LOG_UPD, S_T_MUL, S_T_GET, S_Y_MUL, S_Y_GET,
        S_POW_END, S_SQP_GO, S_SQP_WT, S_PR2, S_PR3, S_MS_HI, S_MS_LO, S_MS_CB,
        S_STEP, S_STEP_WT, S_U_RD, S_U_MUL, S_U_NR, S_U_D2, S_U_DIV,
        S_E_RD, S_E_LD, S_E_WT
    } t_state;

    // Floor square root, elaboration-time use only
    function automatic logic [31:0] f_isqrt64(input logic [63:0] x);
        logic [35:0] rem;
        logic [35:0] trial;
        logic [31:0] root;
        rem  = '0;
        root = '0;
        for (int i = 31; i >= 0; i--) begin
            rem   = {rem[33:0], x[2*i+1 -: 2]};
            trial = {2'b00, root, 2'b01};
            if (rem >= trial) begin
                rem  = rem - trial;
                root = {root[30:0], 1'b1};
            end else begin
                root = {root[30:0], 1'b0};
            end
        end
        return root;
    endfunction

    // Factors 2^(-2^-(i+1)) in Q2.30, built by repeated floor roots
    typedef logic [31:0] t_root_tab [16];

    function automatic t_root_tab f_build_roots();
        t_root_tab   tab;
        logic [63:0] r;
        r = {32'd0, f_isqrt64(64'd1 << 59)};
        for (int i = 0; i < 16; i++) begin
            tab[i] = r[31:0];
            r      = {32'd0, f_isqrt64(r << 30)};
        end
        return tab;
    endfunction

    localparam t_root_tab ROOT_TAB = f_build_roots();

endpackage

// ===== hdl/ogme_isqrt.sv =====
// Iterative floor square root of a 64-bit radicand, one result bit per cycle.
// Depends on nothing; instantiated by the top level.
module ogme_isqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_rad,
    output logic        o_done,
    output logic [31:0] o_root
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [63:0] r_x;
    logic [35:0] r_rem;
    logic [31:0] r_root;

    logic [35:0] rem_sh;
    logic [35:0] trial;
    logic        ge;

    // One digit: bring down two bits, try subtracting 4*root+1
    assign rem_sh = {r_rem[33:0], r_x[63:62]};
    assign trial  = {2'b00, r_root, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_x    <= i_rad;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_x    <= {r_x[61:0], 2'b00};
                r_rem  <= ge ? (rem_sh - trial) : rem_sh;
                r_root <= {r_root[30:0], ge};
                r_cnt  <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ===== hdl/ogme_div.sv =====
// Bit-serial restoring divider: 64-bit dividend by 33-bit divisor, one bit per cycle.
// Depends on nothing; instantiated by the top level.
module ogme_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [32:0] i_den,
    output logic        o_done,
    output logic [63:0] o_quot
);

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [63:0] r_num;
    logic [32:0] r_rem;
    logic [32:0] r_den;

    logic [33:0] rem_sh;
    logic        ge;

    // Shift in the next dividend bit, subtract when it fits
    assign rem_sh = {r_rem, r_num[63]};
    assign ge     = (rem_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem  <= ge ? 33'(rem_sh - {1'b0, r_den}) : rem_sh[32:0];
                r_num  <= {r_num[62:0], ge};
                r_cnt  <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

// ===== hdl/online_geometric_median_estimator_top.sv =====
// Top level of the online geometric median estimator (averaged stochastic gradient).
// Depends on ogme_pkg, ogme_isqrt and ogme_div.
//
// Usage:
//   Input stream: one beat per coordinate. tdata = {sample_weight, coord_value},
//   tuser = action (load init, begin pass, sample), tlast = last coordinate.
//   Output stream: p beats per completed sample vector, the averaged estimate,
//   tdata = {coord_index, estimate_value}, tlast on the final coordinate.
//   Registers: APB, word addresses 0..3 (dimension, gamma, alpha, epsilon).
// Stalls:
//   Loads, begin-pass beats and non-final sample coordinates do not stall the input.
//   A completing sample vector keeps the input stalled through a distance pass per
//   coordinate and a square root; when the distance exceeds epsilon, the power
//   sequence, a second square root, the product chain and the step division (skipped
//   when the step saturates); then an update per coordinate, dominated by the
//   bit-serial divider of the averaging step, and the emission of every beat.
//   The first vector of a pass skips the update and goes straight to emission.
// Reset clears counters and both estimate vectors (via per-entry valid bits).
// When the receiver stalls, the output beat holds and no input is accepted.
module online_geometric_median_estimator_top #(
    parameter int unsigned MAX_DIM = ogme_pkg::MAX_DIM_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // [31:0] coord_value, [63:32] sample_weight
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] action
    input  logic        i_s_axis_tlast,
    // output stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // [31:0] estimate_value, [37:32] coord_index
    output logic        o_m_axis_tlast,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int unsigned PW    = $clog2(MAX_DIM + 1);

    // Configuration registers
    logic [6:0]  r_dim;
    logic [15:0] r_gamma;
    logic [15:0] r_alpha;
    logic [31:0] r_eps;

    // Sequencer and datapath registers
    ogme_pkg::t_state r_state, n_state, r_ret;
    logic [IDX_W-1:0] r_coord;
    logic [IDX_W-1:0] r_i;
    logic [31:0]      r_cnt_smp;
    logic [32:0]      r_k1;
    logic [31:0]      r_weight;
    logic [63:0]      r_sum;
    logic [31:0]      r_dist;
    logic             r_upd;
    logic [32:0]      r_x;
    logic [5:0]       r_e;
    logic [30:0]      r_lx;
    logic [21:0]      r_lg;
    logic [3:0]       r_lc;
    logic [5:0]       r_ti;
    logic [15:0]      r_tf;
    logic [30:0]      r_y;
    logic [30:0]      r_pow;
    logic [63:0]      r_ma;
    logic [31:0]      r_mb;
    logic [4:0]       r_msh;
    logic [63:0]      r_hi;
    logic [63:0]      r_acc;
    logic [31:0]      r_step;
    logic [63:0]      r_mp;
    logic             r_dneg;
    logic [31:0]      r_run;
    logic [31:0]      r_avg;
    logic [31:0]      r_nr;
    logic             r_neg2;

    // Output register
    logic             r_m_tvalid;
    logic [31:0]      r_m_val;
    logic [IDX_W-1:0] r_m_idx;
    logic             r_m_last;

    // Memories: sample buffer, and running/averaged pair per coordinate
    logic [31:0]        buf_mem [MAX_DIM];
    logic [63:0]        ra_mem  [MAX_DIM];
    logic [MAX_DIM-1:0] r_ra_vld;
    logic [31:0]        r_buf_q;
    logic [63:0]        r_ra_q;
    logic               r_ra_q_vld;

    logic               buf_we;
    logic [IDX_W-1:0]   buf_wa;
    logic               ra_we;
    logic [IDX_W-1:0]   ra_wa;
    logic [63:0]        ra_wd;

    // Shared 32x32 multiplier, registered product
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;

    // Arithmetic units
    logic        sq_start, sq_done;
    logic [63:0] sq_rad;
    logic [31:0] sq_root;
    logic        dv_start, dv_done;
    logic [63:0] dv_num;
    logic [32:0] dv_den;
    logic [63:0] dv_quot;

    // Input decode
    logic             s_acc;
    ogme_pkg::t_action act;
    logic [31:0]      in_val;
    logic [PW-1:0]    p_eff;
    logic [IDX_W-1:0] p_last;
    logic [IDX_W-1:0] idx;
    logic             vec_done;
    logic             cfg_wr;

    // Datapath helpers
    logic [31:0]        run_q, avg_q;
    logic signed [32:0] d_s;
    logic [31:0]        mag;
    logic [64:0]        sum_w;
    logic [5:0]         up;
    logic               hi_sat;
    logic [64:0]        cb_sum;
    logic [63:0]        cb;
    logic [32:0]        lsq;
    logic [21:0]        t_val;
    logic [33:0]        dm;
    logic signed [35:0] nr_w;
    logic [31:0]        nr_c;
    logic signed [32:0] d2;
    logic [31:0]        d2_mag;
    logic [31:0]        q32;
    logic [31:0]        avg_new;

    ogme_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_rad   (sq_rad),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    ogme_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (dv_start),
        .i_num   (dv_num),
        .i_den   (dv_den),
        .o_done  (dv_done),
        .o_quot  (dv_quot)
    );

    // Effective dimension and coordinate index
    always_comb begin
        if (r_dim == 7'd0) begin
            p_eff = PW'(1);
        end else if (r_dim > 7'(MAX_DIM)) begin
            p_eff = PW'(MAX_DIM);
        end else begin
            p_eff = PW'(r_dim);
        end
    end

    assign p_last   = IDX_W'(p_eff - PW'(1));
    assign idx      = (PW'(r_coord) < p_eff) ? r_coord : '0;
    assign vec_done = i_s_axis_tlast || (idx == p_last);
    assign s_acc    = i_s_axis_tvalid && o_s_axis_tready;
    assign act      = ogme_pkg::t_action'(i_s_axis_tuser);
    assign in_val   = i_s_axis_tdata[31:0];
    assign cfg_wr   = psel && penable && pwrite;

    // Memory read data; an entry never written reads as zero
    assign run_q = r_ra_q_vld ? r_ra_q[63:32] : 32'd0;
    assign avg_q = r_ra_q_vld ? r_ra_q[31:0]  : 32'd0;

    // Sample minus running estimate, and its magnitude
    assign d_s = {r_buf_q[31], r_buf_q} - {run_q[31], run_q};
    assign mag = d_s[32] ? 32'(-d_s) : d_s[31:0];

    // Saturating accumulate of squared differences
    assign sum_w = {1'b0, r_sum} + {1'b0, r_mp};

    // Saturating (a*b)>>s from the two partial products
    assign up     = 6'd32 - {1'b0, r_msh};
    assign hi_sat = (r_hi >> (6'd32 + {1'b0, r_msh})) != 64'd0;
    assign cb_sum = {1'b0, r_hi << up} + {1'b0, r_mp >> r_msh};
    assign cb     = (hi_sat || cb_sum[64]) ? '1 : cb_sum[63:0];

    // Log squaring step and exponent product
    assign lsq   = r_mp[62:30];
    assign t_val = r_mp[37:16];

    // Running update: capped move, clamped to 32-bit signed
    assign dm   = (r_mp[63:16] > 48'h2_0000_0000) ? 34'h2_0000_0000 : r_mp[49:16];
    assign nr_w = {{4{r_run[31]}}, r_run} + (r_dneg ? -$signed({2'b00, dm})
                                                    :  $signed({2'b00, dm}));
    always_comb begin
        if (nr_w > 36'sd2147483647) begin
            nr_c = 32'h7FFF_FFFF;
        end else if (nr_w < -36'sd2147483648) begin
            nr_c = 32'h8000_0000;
        end else begin
            nr_c = nr_w[31:0];
        end
    end

    // Averaging step, truncated toward zero
    assign d2      = {r_nr[31], r_nr} - {r_avg[31], r_avg};
    assign d2_mag  = d2[32] ? 32'(-d2) : d2[31:0];
    assign q32     = dv_quot[31:0];
    assign avg_new = r_neg2 ? (r_avg - q32) : (r_avg + q32);

    assign mul_p = mul_a * mul_b;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ogme_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and per-state strobes
    always_comb begin
        n_state  = r_state;
        mul_a    = 32'd0;
        mul_b    = 32'd0;
        sq_start = 1'b0;
        sq_rad   = r_sum;
        dv_start = 1'b0;
        dv_num   = {r_acc[47:0], 16'd0};
        dv_den   = {1'b0, r_dist};
        buf_we   = 1'b0;
        buf_wa   = idx;
        ra_we    = 1'b0;
        ra_wa    = idx;
        ra_wd    = {in_val, in_val};
        case (r_state)
            ogme_pkg::S_IDLE: begin
                if (s_acc) begin
                    case (act)
                        ogme_pkg::ACT_LOAD:   ra_we = 1'b1;
                        ogme_pkg::ACT_SAMPLE: begin
                            buf_we = 1'b1;
                            if (vec_done) begin
                                n_state = (r_cnt_smp != 32'd0) ? ogme_pkg::S_D_RD
                                                               : ogme_pkg::S_E_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ogme_pkg::S_D_RD: n_state = ogme_pkg::S_D_SQ;
            ogme_pkg::S_D_SQ: begin
                mul_a   = mag;
                mul_b   = mag;
                n_state = ogme_pkg::S_D_ACC;
            end
            ogme_pkg::S_D_ACC:
                n_state = (r_i == p_last) ? ogme_pkg::S_DIST_GO : ogme_pkg::S_D_RD;
            ogme_pkg::S_DIST_GO: begin
                sq_start = 1'b1;
                n_state  = ogme_pkg::S_DIST_WT;
            end
            ogme_pkg::S_DIST_WT: begin
                if (sq_done) begin
                    n_state = (sq_root > r_eps) ? ogme_pkg::S_NORM : ogme_pkg::S_U_RD;
                end
            end
            ogme_pkg::S_NORM:
                if (r_x[32]) n_state = ogme_pkg::S_LOG_MUL;
            ogme_pkg::S_LOG_MUL: begin
                mul_a   = {1'b0, r_lx};
                mul_b   = {1'b0, r_lx};
                n_state = ogme_pkg::S_LOG_UPD;
            end
            ogme_pkg::S_LOG_UPD:
                n_state = (r_lc == 4'd15) ? ogme_pkg::S_T_MUL : ogme_pkg::S_LOG_MUL;
            ogme_pkg::S_T_MUL: begin
                mul_a   = {16'd0, r_alpha};
                mul_b   = {10'd0, r_lg};
                n_state = ogme_pkg::S_T_GET;
            end
            ogme_pkg::S_T_GET: n_state = ogme_pkg::S_Y_MUL;
            ogme_pkg::S_Y_MUL: begin
                mul_a = {1'b0, r_y};
                mul_b = ogme_pkg::ROOT_TAB[r_lc];
                if (r_tf[4'd15 - r_lc]) begin
                    n_state = ogme_pkg::S_Y_GET;
                end else if (r_lc == 4'd15) begin
                    n_state = ogme_pkg::S_POW_END;
                end
            end
            ogme_pkg::S_Y_GET:
                n_state = (r_lc == 4'd15) ? ogme_pkg::S_POW_END : ogme_pkg::S_Y_MUL;
            ogme_pkg::S_POW_END: n_state = ogme_pkg::S_SQP_GO;
            ogme_pkg::S_SQP_GO: begin
                sq_start = 1'b1;
                sq_rad   = 64'(p_eff) << 32;
                n_state  = ogme_pkg::S_SQP_WT;
            end
            ogme_pkg::S_SQP_WT:
                if (sq_done) n_state = ogme_pkg::S_MS_HI;
            ogme_pkg::S_PR2: n_state = ogme_pkg::S_MS_HI;
            ogme_pkg::S_PR3: n_state = ogme_pkg::S_MS_HI;
            ogme_pkg::S_MS_HI: begin
                mul_a   = r_ma[63:32];
                mul_b   = r_mb;
                n_state = ogme_pkg::S_MS_LO;
            end
            ogme_pkg::S_MS_LO: begin
                mul_a   = r_ma[31:0];
                mul_b   = r_mb;
                n_state = ogme_pkg::S_MS_CB;
            end
            ogme_pkg::S_MS_CB: n_state = r_ret;
            ogme_pkg::S_STEP: begin
                if (r_acc[63:48] != 16'd0) begin
                    n_state = ogme_pkg::S_U_RD;
                end else begin
                    dv_start = 1'b1;
                    n_state  = ogme_pkg::S_STEP_WT;
                end
            end
            ogme_pkg::S_STEP_WT:
                if (dv_done) n_state = ogme_pkg::S_U_RD;
            ogme_pkg::S_U_RD: n_state = ogme_pkg::S_U_MUL;
            ogme_pkg::S_U_MUL: begin
                mul_a   = mag;
                mul_b   = r_step;
                n_state = ogme_pkg::S_U_NR;
            end
            ogme_pkg::S_U_NR: n_state = ogme_pkg::S_U_D2;
            ogme_pkg::S_U_D2: begin
                dv_start = 1'b1;
                dv_num   = 64'(d2_mag);
                dv_den   = r_k1;
                n_state  = ogme_pkg::S_U_DIV;
            end
            ogme_pkg::S_U_DIV: begin
                if (dv_done) begin
                    ra_we   = 1'b1;
                    ra_wa   = r_i;
                    ra_wd   = {r_nr, avg_new};
                    n_state = (r_i == p_last) ? ogme_pkg::S_E_RD : ogme_pkg::S_U_RD;
                end
            end
            ogme_pkg::S_E_RD: n_state = ogme_pkg::S_E_LD;
            ogme_pkg::S_E_LD: n_state = ogme_pkg::S_E_WT;
            ogme_pkg::S_E_WT: begin
                if (i_m_axis_tready) begin
                    n_state = r_m_last ? ogme_pkg::S_IDLE : ogme_pkg::S_E_RD;
                end
            end
            default: n_state = ogme_pkg::S_IDLE;
        endcase
    end

    // Memories: one write port each, read at the current coordinate
    always_ff @(posedge i_clk) begin
        if (buf_we) buf_mem[buf_wa] <= in_val;
        if (ra_we)  ra_mem[ra_wa]   <= ra_wd;
        r_buf_q    <= buf_mem[r_i];
        r_ra_q     <= ra_mem[r_i];
        r_ra_q_vld <= r_ra_vld[r_i];
        r_mp       <= mul_p;
    end

    // Control state, configuration and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim      <= ogme_pkg::DIM_RST;
            r_gamma    <= ogme_pkg::GAMMA_RST;
            r_alpha    <= ogme_pkg::ALPHA_RST;
            r_eps      <= ogme_pkg::EPS_RST;
            r_coord    <= '0;
            r_i        <= '0;
            r_cnt_smp  <= '0;
            r_ra_vld   <= '0;
            r_m_tvalid <= 1'b0;
            r_ret      <= ogme_pkg::S_IDLE;
        end else begin
            // register writes
            if (cfg_wr) begin
                case (ogme_pkg::t_reg_idx'(paddr[3:2]))
                    ogme_pkg::REG_DIM:   r_dim   <= pwdata[6:0];
                    ogme_pkg::REG_GAMMA: r_gamma <= pwdata[15:0];
                    ogme_pkg::REG_ALPHA: r_alpha <= pwdata[15:0];
                    ogme_pkg::REG_EPS:   r_eps   <= pwdata;
                    default: ;
                endcase
            end
            if (ra_we) r_ra_vld[ra_wa] <= 1'b1;

            case (r_state)
                ogme_pkg::S_IDLE: begin
                    if (s_acc) begin
                        case (act)
                            ogme_pkg::ACT_BEGIN: begin
                                r_cnt_smp <= '0;
                                r_coord   <= '0;
                            end
                            ogme_pkg::ACT_LOAD:
                                r_coord <= vec_done ? '0 : idx + 1'b1;
                            ogme_pkg::ACT_SAMPLE: begin
                                r_coord <= vec_done ? '0 : idx + 1'b1;
                                if (vec_done) begin
                                    r_weight <= i_s_axis_tdata[63:32];
                                    r_k1     <= {1'b0, r_cnt_smp} + 33'd1;
                                    if (r_cnt_smp != 32'hFFFF_FFFF) begin
                                        r_cnt_smp <= r_cnt_smp + 32'd1;
                                    end
                                    r_i   <= '0;
                                    r_sum <= '0;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ogme_pkg::S_D_ACC: begin
                    r_sum <= sum_w[64] ? '1 : sum_w[63:0];
                    r_i   <= (r_i == p_last) ? '0 : r_i + 1'b1;
                end
                ogme_pkg::S_DIST_WT: begin
                    if (sq_done) begin
                        r_dist <= sq_root;
                        r_upd  <= (sq_root > r_eps);
                        r_x    <= r_k1;
                        r_e    <= 6'd32;
                    end
                end
                // normalize k+1 so that its leading one sits at bit 32
                ogme_pkg::S_NORM: begin
                    if (r_x[32]) begin
                        r_lx <= r_x[32:2];
                        r_lg <= {r_e, 16'd0};
                        r_lc <= '0;
                    end else begin
                        r_x <= {r_x[31:0], 1'b0};
                        r_e <= r_e - 6'd1;
                    end
                end
                // fractional log bits by squaring
                ogme_pkg::S_LOG_UPD: begin
                    if (lsq[32:31] != 2'b00) begin
                        r_lg <= r_lg | (22'd1 << (4'd15 - r_lc));
                        r_lx <= lsq[31:1];
                    end else begin
                        r_lx <= lsq[30:0];
                    end
                    r_lc <= r_lc + 4'd1;
                end
                ogme_pkg::S_T_GET: begin
                    r_ti <= t_val[21:16];
                    r_tf <= t_val[15:0];
                    r_y  <= 31'h4000_0000;
                    r_lc <= '0;
                end
                ogme_pkg::S_Y_MUL: begin
                    if (!r_tf[4'd15 - r_lc] && r_lc != 4'd15) r_lc <= r_lc + 4'd1;
                end
                ogme_pkg::S_Y_GET: begin
                    r_y  <= r_mp[60:30];
                    r_lc <= r_lc + 4'd1;
                end
                ogme_pkg::S_POW_END:
                    r_pow <= (r_ti >= 6'd31) ? 31'd0 : (r_y >> r_ti);
                // product chain weight*sqrt(p)*gamma*pow
                ogme_pkg::S_SQP_WT: begin
                    if (sq_done) begin
                        r_ma  <= {32'd0, r_weight};
                        r_mb  <= sq_root;
                        r_msh <= 5'd16;
                        r_ret <= ogme_pkg::S_PR2;
                    end
                end
                ogme_pkg::S_PR2: begin
                    r_ma  <= r_acc;
                    r_mb  <= {16'd0, r_gamma};
                    r_msh <= 5'd8;
                    r_ret <= ogme_pkg::S_PR3;
                end
                ogme_pkg::S_PR3: begin
                    r_ma  <= r_acc;
                    r_mb  <= {1'b0, r_pow};
                    r_msh <= 5'd30;
                    r_ret <= ogme_pkg::S_STEP;
                end
                ogme_pkg::S_MS_LO: r_hi  <= r_mp;
                ogme_pkg::S_MS_CB: r_acc <= cb;
                ogme_pkg::S_STEP:
                    if (r_acc[63:48] != 16'd0) r_step <= 32'hFFFF_FFFF;
                ogme_pkg::S_STEP_WT: begin
                    if (dv_done) begin
                        r_step <= (dv_quot[63:32] != 32'd0) ? 32'hFFFF_FFFF : dv_quot[31:0];
                    end
                end
                // per-coordinate update
                ogme_pkg::S_U_MUL: begin
                    r_dneg <= d_s[32];
                    r_run  <= run_q;
                    r_avg  <= avg_q;
                end
                ogme_pkg::S_U_NR: r_nr <= r_upd ? nr_c : r_run;
                ogme_pkg::S_U_D2: r_neg2 <= d2[32];
                ogme_pkg::S_U_DIV: begin
                    if (dv_done) r_i <= (r_i == p_last) ? '0 : r_i + 1'b1;
                end
                // emission of the averaged vector
                ogme_pkg::S_E_LD: begin
                    r_m_tvalid <= 1'b1;
                    r_m_val    <= avg_q;
                    r_m_idx    <= r_i;
                    r_m_last   <= (r_i == p_last);
                end
                ogme_pkg::S_E_WT: begin
                    if (i_m_axis_tready) begin
                        r_m_tvalid <= 1'b0;
                        r_i        <= r_m_last ? '0 : r_i + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        case (ogme_pkg::t_reg_idx'(paddr[3:2]))
            ogme_pkg::REG_DIM:   prdata = {25'd0, r_dim};
            ogme_pkg::REG_GAMMA: prdata = {16'd0, r_gamma};
            ogme_pkg::REG_ALPHA: prdata = {16'd0, r_alpha};
            ogme_pkg::REG_EPS:   prdata = r_eps;
            default:             prdata = 32'd0;
        endcase
    end

    assign pready          = 1'b1;
    assign o_s_axis_tready = (r_state == ogme_pkg::S_IDLE);
    assign o_m_axis_tvalid = r_m_tvalid;
    assign o_m_axis_tdata  = {2'b00, 6'(r_m_idx), r_m_val};
    assign o_m_axis_tlast  = r_m_last;

endmodule

// ===== hdl/ogme_checker.sv =====
// Port-level checks for the geometric median estimator, bound to the top level.
// Depends on online_geometric_median_estimator_top.
module ogme_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [39:0] o_m_axis_tdata,
    input logic        pready
);

    // Input is never taken while a result beat is on offer
    a_no_accept_while_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !o_s_axis_tready)
        else $error("input ready while output beat pending");

    // Reset drops any output beat
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    // Stalled output beat holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("output beat changed under stall");

    // Configuration port never waits
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("pready low");

endmodule

bind online_geometric_median_estimator_top ogme_checker u_ogme_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .pready          (pready)
);
